### hdl/hrpd_pkg.sv
// ----------------------------------------------------------------------------
// hrpd_pkg: shared definitions for the height ramp PD controller
// Fixed-point types, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package hrpd_pkg;

  // Signed Q16.16 value and the unsigned 31 bit UQ15.16 value.
  localparam int unsigned QW  = 32;
  localparam int unsigned UQW = 31;
  localparam int unsigned QFRAC = 16;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [UQW-1:0]       uq_t;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = QW;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIMB_RATE    = 3'd0,
    REG_RAMP_GOAL     = 3'd1,
    REG_TARGET_BOUND  = 3'd2,
    REG_PROP_GAIN     = 3'd3,
    REG_DAMP_GAIN     = 3'd4,
    REG_NEUTRAL_SPEED = 3'd5
  } reg_idx_t;

  // Reset values; 1.0 in Q16.16 is 2^16.
  localparam uq_t CLIMB_RATE_RST   = uq_t'(65536);
  localparam uq_t TARGET_BOUND_RST = uq_t'(65536);

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

endpackage

`default_nettype wire

### hdl/hrpd_if.sv
// ----------------------------------------------------------------------------
// hrpd_if: sample and command channels of the height ramp PD controller
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrpd_sample_if;
  import hrpd_pkg::*;

  logic valid;
  logic ready;
  q_t   height;
  q_t   height_rate;
  uq_t  elapsed;

  modport source (output valid, height, height_rate, elapsed, input ready);
  modport sink   (input valid, height, height_rate, elapsed, output ready);
endinterface

interface hrpd_cmd_if;
  import hrpd_pkg::*;

  logic valid;
  logic ready;
  q_t   prop_speed;

  modport source (output valid, prop_speed, input ready);
  modport sink   (input valid, prop_speed, output ready);
endinterface

`default_nettype wire

### hdl/height_ramp_pd_controller.sv
// ----------------------------------------------------------------------------
// height_ramp_pd_controller: height-hold PD controller with a ramped set point
// Moves a target height toward the goal, bounds it around the measured height
// and issues a saturated propeller speed command, all in signed Q16.16.
// ----------------------------------------------------------------------------
//
// Each sample word (height, height_rate, elapsed) yields exactly one command
// word (prop_speed), in order. The block is a five stage pipeline: an input
// register, the ramp step product climb_rate * elapsed, the target update
// with its bound clamp, the two gain products, and the output register that
// sums and saturates. A new sample is taken in every cycle unless the
// pipeline is full and its finished command has not been taken. The kept
// target height is updated in the third stage, so consecutive samples see
// the target left by the one before them without any wait. Each stage holds
// its word only while the stage after it is full and not moving, so bubbles
// close up and the block keeps taking samples while a finished command
// waits to be taken. A sample with zero elapsed time passes through without
// touching the target and yields the neutral speed. Configuration registers
// are written through a plain write port and must only change while no
// sample is inside the pipeline.
//
`default_nettype none

module height_ramp_pd_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [hrpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrpd_pkg::CFG_DATA_W-1:0] cfg_data,
  hrpd_sample_if.sink                        sample,
  hrpd_cmd_if.source                         command
);
  import hrpd_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  uq_t climb_rate;
  q_t  ramp_goal;
  uq_t target_bound;
  q_t  prop_gain;
  q_t  damp_gain;
  q_t  neutral_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      climb_rate    <= CLIMB_RATE_RST;
      ramp_goal     <= '0;
      target_bound  <= TARGET_BOUND_RST;
      prop_gain     <= '0;
      damp_gain     <= '0;
      neutral_speed <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CLIMB_RATE:    climb_rate    <= cfg_data[UQW-1:0];
        REG_RAMP_GOAL:     ramp_goal     <= cfg_data;
        REG_TARGET_BOUND:  target_bound  <= cfg_data[UQW-1:0];
        REG_PROP_GAIN:     prop_gain     <= cfg_data;
        REG_DAMP_GAIN:     damp_gain     <= cfg_data;
        REG_NEUTRAL_SPEED: neutral_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage can load when it is empty or its word
  // moves on in the same cycle.
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic s1_load, s2_load, s3_load, s4_load, out_load;

  assign out_load = !out_valid || command.ready;
  assign s4_load  = !s4_valid  || out_load;
  assign s3_load  = !s3_valid  || s4_load;
  assign s2_load  = !s2_valid  || s3_load;
  assign s1_load  = !s1_valid  || s2_load;

  assign sample.ready = s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load)  s1_valid  <= sample.valid;
      if (s2_load)  s2_valid  <= s1_valid;
      if (s3_load)  s3_valid  <= s2_valid;
      if (s4_load)  s4_valid  <= s3_valid;
      if (out_load) out_valid <= s4_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  q_t  s1_height;
  q_t  s1_height_rate;
  uq_t s1_elapsed;

  always_ff @(posedge clk) begin
    if (s1_load && sample.valid) begin
      s1_height      <= sample.height;
      s1_height_rate <= sample.height_rate;
      s1_elapsed     <= sample.elapsed;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: ramp step = floor(climb_rate * elapsed / 2^16), saturated to the
  // positive signed 32 bit range so that it fits 31 bits.
  // --------------------------------------------------------------------------
  localparam int unsigned STEP_PW = 2 * UQW;

  logic [STEP_PW-1:0] step_prod;
  uq_t                step_sat;

  assign step_prod = climb_rate * s1_elapsed;
  assign step_sat  = (|step_prod[STEP_PW-1:QFRAC+UQW]) ? {UQW{1'b1}}
                                                       : step_prod[QFRAC+UQW-1:QFRAC];

  q_t   s2_height;
  q_t   s2_height_rate;
  uq_t  s2_step;
  logic s2_skip;

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_height      <= s1_height;
      s2_height_rate <= s1_height_rate;
      s2_step        <= step_sat;
      s2_skip        <= (s1_elapsed == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: target update. The target moves toward the goal by the step and
  // lands on the goal when closer than one step, so the ramped value always
  // lies between the old target and the goal. It is then clamped to within
  // target_bound of the measured height.
  // --------------------------------------------------------------------------
  q_t                 target_level;
  logic signed [QW:0] goal_diff;
  logic [QW:0]        goal_dist;
  q_t                 ramp_level;
  logic signed [QW:0] ramp_ext;
  logic signed [QW:0] bound_hi;
  logic signed [QW:0] bound_lo;
  logic signed [QW:0] clamp_ext;
  q_t                 target_next;
  logic signed [QW:0] height_ext;
  logic signed [QW:0] err_ext;
  q_t                 err_p;
  q_t                 err_d;

  always_comb begin
    goal_diff = $signed({ramp_goal[QW-1], ramp_goal})
              - $signed({target_level[QW-1], target_level});
    goal_dist = goal_diff[QW] ? (QW+1)'(-goal_diff) : goal_diff;

    if (goal_dist < {2'b00, s2_step}) begin
      ramp_level = ramp_goal;
    end else if (goal_diff[QW]) begin
      ramp_level = target_level - $signed({1'b0, s2_step});
    end else begin
      ramp_level = target_level + $signed({1'b0, s2_step});
    end
    ramp_ext = $signed({ramp_level[QW-1], ramp_level});

    height_ext = $signed({s2_height[QW-1], s2_height});
    bound_hi   = height_ext + $signed({2'b00, target_bound});
    bound_lo   = height_ext - $signed({2'b00, target_bound});

    priority if (ramp_ext > bound_hi) begin
      clamp_ext = bound_hi;
    end else if (ramp_ext < bound_lo) begin
      clamp_ext = bound_lo;
    end else begin
      clamp_ext = ramp_ext;
    end
    // A clamped value lies between the ramped target and the measured
    // height, so it always fits the signed 32 bit range.
    target_next = clamp_ext[QW-1:0];

    // The clamp keeps |target - height| within a 31 bit bound, so the
    // height error never needs saturation.
    err_ext = clamp_ext - height_ext;
    err_p   = err_ext[QW-1:0];

    // Negated rate saturates only for the most negative input.
    err_d = (s2_height_rate == Q_MIN) ? Q_MAX : -s2_height_rate;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= '0;
    end else if (s3_load && s2_valid && !s2_skip) begin
      target_level <= target_next;
    end
  end

  q_t   s3_err_p;
  q_t   s3_err_d;
  logic s3_skip;

  always_ff @(posedge clk) begin
    if (s3_load && s2_valid) begin
      s3_err_p <= err_p;
      s3_err_d <= err_d;
      s3_skip  <= s2_skip;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: gain products, exact in 64 bits, then an arithmetic shift right
  // by 16 (rounding toward minus infinity).
  // --------------------------------------------------------------------------
  localparam int unsigned PROD_W = 2 * QW;
  localparam int unsigned TERM_W = PROD_W - QFRAC;

  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_d;

  assign prod_p = prop_gain * s3_err_p;
  assign prod_d = damp_gain * s3_err_d;

  logic signed [TERM_W-1:0] s4_term_p;
  logic signed [TERM_W-1:0] s4_term_d;
  logic                     s4_skip;

  always_ff @(posedge clk) begin
    if (s4_load && s3_valid) begin
      s4_term_p <= prod_p[PROD_W-1:QFRAC];
      s4_term_d <= prod_d[PROD_W-1:QFRAC];
      s4_skip   <= s3_skip;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: neutral speed plus both terms, saturated to signed 32 bits (neutral speed on a skip).
  // --------------------------------------------------------------------------
  localparam int unsigned SUM_W = TERM_W + 2;

  logic signed [SUM_W-1:0] speed_sum;
  q_t                      speed_sat;

  always_comb begin
    speed_sum = SUM_W'(neutral_speed) + SUM_W'(s4_term_p) + SUM_W'(s4_term_d);
    priority if (speed_sum > SUM_W'(Q_MAX)) begin
      speed_sat = Q_MAX;
    end else if (speed_sum < SUM_W'(Q_MIN)) begin
      speed_sat = Q_MIN;
    end else begin
      speed_sat = speed_sum[QW-1:0];
    end
  end

  q_t prop_speed;

  always_ff @(posedge clk) begin
    if (out_load && s4_valid) begin
      prop_speed <= s4_skip ? neutral_speed : speed_sat;
    end
  end

  assign command.valid      = out_valid;
  assign command.prop_speed = prop_speed;

endmodule

`default_nettype wire
